// ===== rtl/tga_pixel_data_decoder_assert.svh =====
// Assertion macros shared by the TGA pixel data decoder queue and result sequencer.
`ifndef TGA_PIXEL_DATA_DECODER_ASSERT_SVH
`define TGA_PIXEL_DATA_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpd assertion failed");

// Next-cycle implication, checked outside reset.
`define TPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpd assertion failed");

`endif

// ===== rtl/tpd_pkg.sv =====
// Package for the TGA pixel data decoder: codes, job and status types.
`default_nettype none

package tpd_pkg;

  // Pixel mode codes
  localparam logic [2:0] MODE_RAW24 = 3'd0;
  localparam logic [2:0] MODE_RAW32 = 3'd1;
  localparam logic [2:0] MODE_RAW16 = 3'd2;
  localparam logic [2:0] MODE_GREY8 = 3'd3;
  localparam logic [2:0] MODE_RLE24 = 3'd4;
  localparam logic [2:0] MODE_RLE32 = 3'd5;

  // Configuration register indexes
  localparam logic CFG_PIXEL_MODE  = 1'b0;
  localparam logic CFG_PIXEL_TOTAL = 1'b1;

  localparam int unsigned TOTAL_W = 30;

  // One decoded pixel and how many times it goes out
  typedef struct packed {
    logic [31:0] px;
    logic [7:0]  len;
    logic        done;
  } tpd_job_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } tpd_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/tpd_front.sv =====
// Front end: accepts stream beats, parses RLE packets and assembles pixels.
`default_nettype none

module tpd_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [29:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_data_byte,
  input  wire tpd_pkg::tpd_qstat_t  qstat,
  output logic                      job_push,
  output tpd_pkg::tpd_job_t         job
);
  import tpd_pkg::*;

  logic [2:0]         mode_r, mode_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] left_r, left_nxt;
  logic [7:0]         pkt_r, pkt_nxt;
  logic               run_r, run_nxt;
  logic [31:0]        asm_r, asm_nxt;
  logic [1:0]         idx_r, idx_nxt;

  logic        accept, active, rle;
  logic [1:0]  need, idx_inc;
  logic [31:0] asm_new, px;
  logic [7:0]  len_raw, len_clamp;
  logic [TOTAL_W-1:0] left_dec;
  logic [7:0]  pkt_dec;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;
  assign rle      = (mode_r == MODE_RLE24) || (mode_r == MODE_RLE32);
  assign active   = (mode_r <= MODE_RLE32) && !((left_r == '0) && (pkt_r == '0));
  assign left_dec = left_r - TOTAL_W'(1);
  assign pkt_dec  = pkt_r - 8'd1;

  // Bytes per pixel, two bits with four wrapping to zero
  always_comb begin
    unique case (mode_r)
      MODE_RAW24, MODE_RLE24: need = 2'd3;
      MODE_RAW32, MODE_RLE32: need = 2'd0;
      MODE_RAW16:             need = 2'd2;
      default:                need = 2'd1;
    endcase
  end

  // Byte placement into the pixel being gathered
  always_comb begin
    asm_new = asm_r;
    unique case (idx_r)
      2'd0: asm_new[7:0]   = in_data_byte;
      2'd1: asm_new[15:8]  = in_data_byte;
      2'd2: asm_new[23:16] = in_data_byte;
      2'd3: asm_new[31:24] = in_data_byte;
    endcase
  end
  assign idx_inc = idx_r + 2'd1;

  // Colour expansion of a finished pixel
  always_comb begin
    unique case (mode_r)
      MODE_RAW16: px = {{8{asm_new[15]}}, asm_new[4:0], 3'b000,
                        asm_new[9:5], 3'b000, asm_new[14:10], 3'b000};
      MODE_GREY8: px = {8'hFF, asm_new[7:0], asm_new[7:0], asm_new[7:0]};
      default:    px = asm_new;
    endcase
  end

  // Packet length, clamped to the pixels still to come
  assign len_raw   = {1'b0, in_data_byte[6:0]} + 8'd1;
  assign len_clamp = (left_r < TOTAL_W'(len_raw)) ? left_r[7:0] : len_raw;

  // Next state and job generation
  always_comb begin
    mode_nxt  = mode_r;
    total_nxt = total_r;
    left_nxt  = left_r;
    pkt_nxt   = pkt_r;
    run_nxt   = run_r;
    asm_nxt   = asm_r;
    idx_nxt   = idx_r;
    job_push  = 1'b0;
    job.px    = px;
    job.len   = 8'd1;
    job.done  = 1'b0;
    if (cfg_we) begin
      if (cfg_index == CFG_PIXEL_MODE) begin
        mode_nxt = cfg_wdata[2:0];
      end else begin
        total_nxt = cfg_wdata;
      end
      left_nxt = (cfg_index == CFG_PIXEL_TOTAL) ? cfg_wdata : total_r;
      pkt_nxt  = '0;
      run_nxt  = 1'b0;
      asm_nxt  = '0;
      idx_nxt  = '0;
    end else if (accept && active) begin
      if (rle && (pkt_r == '0)) begin
        left_nxt = left_r - TOTAL_W'(len_clamp);
        pkt_nxt  = len_clamp;
        run_nxt  = in_data_byte[7];
        asm_nxt  = '0;
        idx_nxt  = '0;
      end else if (idx_inc != need) begin
        asm_nxt = asm_new;
        idx_nxt = idx_inc;
      end else begin
        asm_nxt  = '0;
        idx_nxt  = '0;
        job_push = 1'b1;
        if (!rle) begin
          left_nxt = left_dec;
          job.done = (left_dec == '0);
        end else if (run_r) begin
          pkt_nxt  = '0;
          job.len  = pkt_r;
          job.done = (left_r == '0);
        end else begin
          pkt_nxt  = pkt_dec;
          job.done = (pkt_dec == '0) && (left_r == '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RAW24;
      total_r <= TOTAL_W'(1);
      left_r  <= TOTAL_W'(1);
      pkt_r   <= '0;
      run_r   <= 1'b0;
      asm_r   <= '0;
      idx_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      total_r <= total_nxt;
      left_r  <= left_nxt;
      pkt_r   <= pkt_nxt;
      run_r   <= run_nxt;
      asm_r   <= asm_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tpd_queue.sv =====
// Job queue between the front end and the result sequencer.
`default_nettype none

`include "tga_pixel_data_decoder_assert.svh"

module tpd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                flush,
  input  wire logic                push,
  input  wire tpd_pkg::tpd_job_t   push_data,
  input  wire logic                pop,
  output tpd_pkg::tpd_job_t        pop_data,
  output tpd_pkg::tpd_qstat_t      qstat
);
  import tpd_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  tpd_job_t        mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == CW'(DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign pop_data    = mem_r[rp_r];

  // Pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (flush) begin
      wp_nxt  = '0;
      rp_nxt  = '0;
      cnt_nxt = '0;
    end else begin
      if (push) begin
        wp_nxt = (wp_r == LAST) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_nxt = (rp_r == LAST) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_nxt = cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push && !flush) begin
      mem_r[wp_r] <= push_data;
    end
  end

  `TPD_ASSERT_NOW(a_no_overflow, push, !qstat.full)
  `TPD_ASSERT_NOW(a_no_underflow, pop, !qstat.empty)
  `TPD_ASSERT_NEXT(a_fill_up, push && !pop && !flush, cnt_r == $past(cnt_r) + CW'(1))

endmodule

`default_nettype wire

// ===== rtl/tpd_back.sv =====
// Result sequencer: turns jobs into result beats of one or two pixels.
`default_nettype none

`include "tga_pixel_data_decoder_assert.svh"

module tpd_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                flush,
  input  wire tpd_pkg::tpd_qstat_t qstat,
  input  wire tpd_pkg::tpd_job_t   job,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [31:0]              out_first_pixel,
  output logic [31:0]              out_second_pixel,
  output logic [1:0]               out_pixel_count,
  output logic                     out_image_done,
  output logic                     out_run_end
);
  import tpd_pkg::*;

  logic        busy_r, busy_nxt;
  logic [31:0] px_r, px_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic        done_r, done_nxt;
  logic        last, pair, accept;

  assign pair   = (rem_r >= 8'd2);
  assign last   = (rem_r <= 8'd2);
  assign accept = busy_r && !out_stall;
  assign pop    = !flush && !qstat.empty && (!busy_r || (accept && last));

  // Result beat from the current job
  assign out_valid        = busy_r;
  assign out_first_pixel  = px_r;
  assign out_second_pixel = pair ? px_r : 32'd0;
  assign out_pixel_count  = pair ? 2'd2 : 2'd1;
  assign out_image_done   = done_r && last;
  assign out_run_end      = last;

  // Advance through the job, load the next one when it ends
  always_comb begin
    busy_nxt = busy_r;
    px_nxt   = px_r;
    rem_nxt  = rem_r;
    done_nxt = done_r;
    if (flush) begin
      busy_nxt = 1'b0;
    end else if (pop) begin
      busy_nxt = 1'b1;
      px_nxt   = job.px;
      rem_nxt  = job.len;
      done_nxt = job.done;
    end else if (accept) begin
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        rem_nxt = rem_r - 8'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    rem_r  <= rem_nxt;
    done_r <= done_nxt;
  end

  `TPD_ASSERT_NOW(a_done_ends_run, out_valid && out_image_done, out_run_end)
  `TPD_ASSERT_NOW(a_mid_run_pair, out_valid && !out_run_end, out_pixel_count == 2'd2)
  `TPD_ASSERT_NEXT(a_mid_run_hold, accept && !last && !flush, busy_r)

endmodule

`default_nettype wire

// ===== rtl/tga_pixel_data_decoder.sv =====
// TGA pixel data decoder top level.
//
// Input channel: one pixel-data byte per beat (in_valid, in_stall,
// in_data_byte). Output channel: one beat carries one or two decoded pixels
// with a pixel count, an image-done flag and a flag for the last beat caused
// by the input byte. Configuration: cfg_we writes pixel_mode (index 0) or
// pixel_total (index 1); every write restarts decoding of a new image.
// Path: a byte that completes a pixel pushes a job at the edge it is taken;
// the job waits in the queue until the result stage is free, which then
// loads it into its registers and raises out_valid.
// Throughput: raw and expanded modes take one byte a cycle while in_stall is
// low and give one beat per finished pixel (every 3, 4, 2 or 1 bytes); an RLE
// run of N pixels gives ceil(N/2) beats, one a cycle while out_stall is low,
// and input stalls once the job queue is full.
// A packet byte gives no beat.
// Reset: pixel_mode 0, pixel_total 1, queue and result stage empty.
// A stalled receiver holds the current beat; the front end keeps taking
// bytes until the queue fills, then raises in_stall.
`default_nettype none

module tga_pixel_data_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [29:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_first_pixel,
  output logic [31:0]      out_second_pixel,
  output logic [1:0]       out_pixel_count,
  output logic             out_image_done,
  output logic             out_run_end
);
  import tpd_pkg::*;

  tpd_qstat_t qstat;
  tpd_job_t   push_job, pop_job;
  logic       push, pop;

  tpd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .qstat        (qstat),
    .job_push     (push),
    .job          (push_job)
  );

  tpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (cfg_we),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .pop_data  (pop_job),
    .qstat     (qstat)
  );

  tpd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .flush            (cfg_we),
    .qstat            (qstat),
    .job              (pop_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_pixel  (out_first_pixel),
    .out_second_pixel (out_second_pixel),
    .out_pixel_count  (out_pixel_count),
    .out_image_done   (out_image_done),
    .out_run_end      (out_run_end)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tga_pixel_data_decoder_tb.sv =====
// Self-checking testbench for the TGA pixel data decoder: predictor, stimulus and beat checks.
module tga_pixel_data_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpd_pkg::*;

  // Mode codes the decoder treats as unused
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;
  localparam logic [29:0] TOTAL_MAX = 30'd1073676289;

  typedef struct {
    logic [31:0] first_px;
    logic [31:0] second_px;
    logic [1:0]  count;
    logic        done;
    logic        run_end;
  } pix_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_PIXEL_MODE;
  logic [29:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_first_pixel;
  logic [31:0] out_second_pixel;
  logic [1:0]  out_pixel_count;
  logic        out_image_done;
  logic        out_run_end;

  tga_pixel_data_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_pixel  (out_first_pixel),
    .out_second_pixel (out_second_pixel),
    .out_pixel_count  (out_pixel_count),
    .out_image_done   (out_image_done),
    .out_run_end      (out_run_end)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Decoder state as the predictor sees it
  logic [2:0]  img_mode;
  logic [29:0] img_total;
  logic [29:0] px_left;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [31:0] asm_word;
  int          asm_count;

  pix_beat_t pixel_beats_due[$];
  pix_beat_t want;
  int        bytes_used = 0;
  int        fail_count = 0;

  // Idling controls
  bit tx_no_gaps = 1'b0;
  bit rx_no_gaps = 1'b0;
  int rx_wait = 0;
  int rx_hold = 0;

  function automatic void restart_image();
    px_left   = img_total;
    pkt_left  = '0;
    pkt_run   = 1'b0;
    asm_word  = '0;
    asm_count = 0;
  endfunction

  // Works out the beats one accepted byte causes and queues them
  function automatic void decode_byte(input logic [7:0] b);
    logic [29:0] len;
    logic [31:0] px;
    logic [15:0] p;
    pix_beat_t   beat;
    int          need;
    if (img_mode > MODE_RLE32) return;
    if (px_left == 0 && pkt_left == 0) return;
    bytes_used++;
    // packet byte: bit 7 run flag, low bits length minus one, clamped
    if (img_mode >= MODE_RLE24 && pkt_left == 0) begin
      len = 30'(b[6:0]) + 30'd1;
      if (len > px_left) len = px_left;
      px_left   = px_left - len;
      pkt_left  = len[7:0];
      pkt_run   = b[7];
      asm_word  = '0;
      asm_count = 0;
      return;
    end
    case (img_mode)
      MODE_RAW24, MODE_RLE24: need = 3;
      MODE_RAW32, MODE_RLE32: need = 4;
      MODE_RAW16:             need = 2;
      default:                need = 1;
    endcase
    asm_word = asm_word | (32'(b) << (8 * asm_count));
    asm_count++;
    if (asm_count < need) return;
    px = asm_word;
    asm_word = '0;
    asm_count = 0;
    // ARGB1555 to R,G,B,A bytes; grey to g,g,g,opaque
    if (img_mode == MODE_RAW16) begin
      p = px[15:0];
      px = {p[15] ? 8'hFF : 8'h00, p[4:0], 3'b000, p[9:5], 3'b000, p[14:10], 3'b000};
    end else if (img_mode == MODE_GREY8) begin
      px = {8'hFF, px[7:0], px[7:0], px[7:0]};
    end
    beat.first_px  = px;
    beat.second_px = '0;
    beat.count     = 2'd1;
    beat.run_end   = 1'b1;
    if (img_mode < MODE_RLE24) begin
      px_left = px_left - 30'd1;
      beat.done = (px_left == 0);
      pixel_beats_due.push_back(beat);
    end else if (pkt_run) begin
      // a run goes out two pixels per beat, one in an odd last beat
      while (pkt_left != 0) begin
        if (pkt_left >= 2) begin
          beat.second_px = px;
          beat.count = 2'd2;
          pkt_left = pkt_left - 8'd2;
        end else begin
          beat.second_px = '0;
          beat.count = 2'd1;
          pkt_left = '0;
        end
        beat.run_end = (pkt_left == 0);
        beat.done = (pkt_left == 0 && px_left == 0);
        pixel_beats_due.push_back(beat);
      end
    end else begin
      pkt_left = pkt_left - 8'd1;
      beat.done = (pkt_left == 0 && px_left == 0);
      pixel_beats_due.push_back(beat);
    end
  endfunction

  // Offer one byte after a drawn gap, hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_byte(b);
  endtask

  // Sender stops and waits for every outstanding beat
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixel_beats_due.size() != 0);
  endtask

  // Drained, plus a wait for any job still in flight
  task automatic wait_idle();
    wait_drain();
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers; each write restarts the image
  task automatic set_regs(input logic [2:0] mode, input logic [29:0] total);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_PIXEL_MODE;
    cfg_wdata <= 30'(mode);
    @(posedge clk);
    img_mode = mode;
    restart_image();
    cfg_index <= CFG_PIXEL_TOTAL;
    cfg_wdata <= total;
    @(posedge clk);
    img_total = total;
    restart_image();
    cfg_we <= 1'b0;
  endtask

  // Receiver: a drawn wait after each beat, plus an optional long hold
  always @(posedge clk) begin
    if (out_valid && !out_stall) rx_wait = rx_no_gaps ? 0 : $urandom_range(0, 12);
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Each taken result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_beats_due.size() == 0) begin
        $error("unexpected beat: first_pixel %h", out_first_pixel);
        fail_count++;
      end else begin
        want = pixel_beats_due.pop_front();
        if (out_first_pixel !== want.first_px) begin
          $error("first_pixel: expected %h, got %h", want.first_px, out_first_pixel);
          fail_count++;
        end
        if (out_second_pixel !== want.second_px) begin
          $error("second_pixel: expected %h, got %h", want.second_px, out_second_pixel);
          fail_count++;
        end
        if (out_pixel_count !== want.count) begin
          $error("pixel_count: expected %0d, got %0d", want.count, out_pixel_count);
          fail_count++;
        end
        if (out_image_done !== want.done) begin
          $error("image_done: expected %b, got %b", want.done, out_image_done);
          fail_count++;
        end
        if (out_run_end !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, out_run_end);
          fail_count++;
        end
      end
    end
  end

  // Reset defaults: raw24, one pixel, then the image is finished
  task automatic test_reset_state();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7F);
  endtask

  // Pass-through and expanding raw modes
  task automatic test_raw_modes();
    set_regs(MODE_RAW32, 30'd1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'hAA);
    set_regs(MODE_RAW16, 30'd2);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h7F);
    set_regs(MODE_GREY8, TOTAL_MAX);
    send_byte(8'hFF);
  endtask

  // Run and raw packets, length clamped, totals beyond 16 bits
  task automatic test_rle_modes();
    set_regs(MODE_RLE24, 30'd3);
    send_byte(8'h81);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h7F);
    send_byte(8'hFE);
    send_byte(8'h01);
    send_byte(8'hC3);
    set_regs(MODE_RLE32, 30'd65537);
    send_byte(8'hFF);
    send_byte(8'hDE);
    send_byte(8'hAD);
    send_byte(8'hBE);
    send_byte(8'hEF);
  endtask

  // Unused mode and an empty image take bytes and give nothing
  task automatic test_ignored_bytes();
    set_regs(MODE_SPARE_B, 30'd5);
    send_byte(8'h9C);
    set_regs(MODE_RAW24, 30'd0);
    send_byte(8'h3B);
  endtask

  // Receiver holds off while the sender streams runs; then a full drain
  task automatic test_backpressure();
    set_regs(MODE_RLE24, 30'd60);
    tx_no_gaps = 1'b1;
    rx_hold = 150;
    repeat (6) begin
      send_byte(8'h89);
      repeat (3) send_byte(8'($urandom_range(0, 255)));
    end
    wait_drain();
    tx_no_gaps = 1'b0;
  endtask

  // Random images: mostly well-formed packet streams, some noise
  task automatic test_random_images();
    logic [2:0]  mode;
    logic [29:0] total;
    logic [7:0]  b;
    int          pick;
    int          cap;
    int          pause_at;
    int          trailing;
    bytes_used = 0;
    while (bytes_used < 300) begin
      pick = $urandom_range(0, 19);
      if (pick < 18) mode = 3'(pick % 6);
      else mode = (pick == 18) ? MODE_SPARE_A : MODE_SPARE_B;
      pick = $urandom_range(0, 19);
      if (pick == 0) total = '0;
      else if (pick < 14) total = 30'($urandom_range(1, 24));
      else if (pick < 18) total = 30'($urandom_range(100, 300));
      else begin
        case ($urandom_range(0, 3))
          0: total = TOTAL_MAX;
          1: total = 30'h3FFEFFFF;
          2: total = 30'd65536;
          default: total = 30'h7FFF;
        endcase
      end
      set_regs(mode, total);
      tx_no_gaps = ($urandom_range(0, 3) == 0);
      rx_no_gaps = ($urandom_range(0, 3) == 0);
      cap = (mode > MODE_RLE32 || total == 0) ? 3 : $urandom_range(8, 60);
      pause_at = $urandom_range(0, 3 * cap);
      trailing = 0;
      for (int i = 0; i < cap && trailing < 3; i++) begin
        if (px_left == 0 && pkt_left == 0) trailing++;
        if (img_mode >= MODE_RLE24 && img_mode <= MODE_RLE32 && pkt_left == 0 &&
            px_left != 0 && $urandom_range(0, 19) != 0) begin
          // packet byte with a mostly short length
          b[7]   = 1'($urandom_range(0, 1));
          b[6:0] = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(0, 9));
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        send_byte(b);
        if (i == pause_at) wait_drain();
      end
    end
    tx_no_gaps = 1'b0;
    rx_no_gaps = 1'b0;
  endtask

  initial begin
    img_mode = MODE_RAW24;
    img_total = 30'd1;
    restart_image();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_raw_modes();
    test_rle_modes();
    test_ignored_bytes();
    test_backpressure();
    test_random_images();
    wait_drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit, well past the slowest correct run
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
